[hdl/ptts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int NUM_TASKS_DEF = 8;

  localparam int FUNC_W   = 2;
  localparam int TIDX_W   = 3;
  localparam int TIME16_W = 16;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY_MODE = 1'd0,
    REG_TASK_COUNT  = 1'd1
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_RESTART = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // static task parameters, written by a load
  typedef struct packed {
    logic [TIME16_W-1:0] exec_time;
    logic [TIME16_W-1:0] period;
    logic [TIME16_W-1:0] rel_deadline;
  } task_rec_t;

  // per-task run state, written by a tick
  typedef struct packed {
    logic [TIME16_W-1:0] remaining;
    logic [TIME_W-1:0]   next_release;
    logic [TIME_W-1:0]   abs_deadline;
  } run_rec_t;

endpackage

[hdl/ptts_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_cmd_if / ptts_slot_if
// Valid/ready channels of the scheduler: command words in, slot words out.
// ----------------------------------------------------------------------------
interface ptts_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [ptts_pkg::FUNC_W-1:0]         func;
  logic [ptts_pkg::TIDX_W-1:0]         task_index;
  logic [ptts_pkg::TIME16_W-1:0]       exec_time;
  logic [ptts_pkg::TIME16_W-1:0]       period;
  logic [ptts_pkg::TIME16_W-1:0]       rel_deadline;

  modport source (output valid, func, task_index, exec_time, period, rel_deadline,
                  input ready);
  modport sink (input valid, func, task_index, exec_time, period, rel_deadline,
                output ready);
endinterface

interface ptts_slot_if;
  logic                                valid;
  logic                                ready;
  logic [ptts_pkg::TIME_W-1:0]         tick_time;
  logic [ptts_pkg::TIDX_W-1:0]         selected_task;
  logic                                idle;

  modport source (output valid, tick_time, selected_task, idle, input ready);
  modport sink (input valid, tick_time, selected_task, idle, output ready);
endinterface

[hdl/ptts_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/periodic_task_tick_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Preemptive periodic-task scheduler, rate monotonic or earliest deadline
// first, with task parameters and run state kept in two small RAMs.
//
//   channel  dir  handshake     words
//   cfg      in   cfg_we        policy_mode, task_count writes
//   cmd      in   valid/ready   load, tick, restart
//   slot     out  valid/ready   tick_time, selected_task, idle per tick
//
// Load and restart complete in the idle state that accepts them. A tick scans
// the table (task_count saturated to NUM_TASKS), one entry per cycle through
// both RAM read ports, then does the decrement write-back in the finish state.
// Reset clears per-entry valid flops at once; no memory clearing pass.
// A tick waits in its last cycle while the slot output register is full.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
  parameter int NUM_TASKS = ptts_pkg::NUM_TASKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ptts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptts_pkg::CFG_DATA_W-1:0]   cfg_data,
  ptts_cmd_if.sink                          cmd,
  ptts_slot_if.source                       slot
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W = $clog2(NUM_TASKS + 1);
  localparam int TAB_W = $bits(ptts_pkg::task_rec_t);
  localparam int RUN_W = $bits(ptts_pkg::run_rec_t);

  ptts_pkg::state_t state;
  ptts_pkg::state_t state_next;

  logic                                policy_mode;
  logic [ptts_pkg::COUNT_W-1:0]        task_count;
  logic [ptts_pkg::TIME_W-1:0]         tick_counter;
  logic [NUM_TASKS-1:0]                work_valid;
  logic [NUM_TASKS-1:0]                dl_valid;
  logic [IDX_W-1:0]                    proc_idx;
  logic                                found;
  logic [IDX_W-1:0]                    best_idx;
  logic [ptts_pkg::TIME_W-1:0]         best_key;
  ptts_pkg::run_rec_t                  best_rec;

  logic                                slot_valid;
  logic [ptts_pkg::TIME_W-1:0]         slot_time;
  logic [ptts_pkg::TIDX_W-1:0]         slot_task;
  logic                                slot_idle;

  logic                                tab_we;
  logic [IDX_W-1:0]                    tab_waddr;
  ptts_pkg::task_rec_t                 tab_wdata;
  ptts_pkg::task_rec_t                 tab_rdata;
  logic                                run_we;
  logic [IDX_W-1:0]                    run_waddr;
  ptts_pkg::run_rec_t                  run_wdata;
  ptts_pkg::run_rec_t                  run_rdata;
  logic [IDX_W-1:0]                    rd_addr;

  logic [CNT_W-1:0]                    active_n;
  logic                                last_entry;
  logic                                cmd_go;
  logic                                load_ok;
  logic                                slot_free;
  ptts_pkg::run_rec_t                  cur_rec;
  ptts_pkg::run_rec_t                  new_rec;
  ptts_pkg::run_rec_t                  dec_rec;
  logic                                released;
  logic [ptts_pkg::TIME_W-1:0]         cand_key;
  logic                                take;

  // memories
  ptts_ram #(.WIDTH(TAB_W), .DEPTH(NUM_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (rd_addr),
    .rdata (tab_rdata)
  );

  ptts_ram #(.WIDTH(RUN_W), .DEPTH(NUM_TASKS)) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (run_waddr),
    .wdata (run_wdata),
    .raddr (rd_addr),
    .rdata (run_rdata)
  );

  // derived control
  always_comb begin
    if (32'(task_count) > 32'(NUM_TASKS)) begin
      active_n = CNT_W'(NUM_TASKS);
    end else begin
      active_n = CNT_W'(task_count);
    end
  end

  assign last_entry = (CNT_W'(proc_idx) + CNT_W'(1)) == active_n;
  assign cmd_go     = cmd.valid && cmd.ready;
  assign load_ok    = 32'(cmd.task_index) < 32'(NUM_TASKS);
  assign slot_free  = !slot_valid || slot.ready;

  // release and selection for the entry in flight
  always_comb begin
    cur_rec.remaining    = work_valid[proc_idx] ? run_rdata.remaining : '0;
    cur_rec.next_release = work_valid[proc_idx] ? run_rdata.next_release : '0;
    cur_rec.abs_deadline = dl_valid[proc_idx] ? run_rdata.abs_deadline : '0;

    released = cur_rec.next_release == tick_counter;
    new_rec  = cur_rec;
    if (released) begin
      new_rec.remaining    = tab_rdata.exec_time;
      new_rec.abs_deadline = tick_counter + 32'(tab_rdata.rel_deadline);
      new_rec.next_release = cur_rec.next_release + 32'(tab_rdata.period);
    end

    cand_key = policy_mode ? new_rec.abs_deadline : 32'(tab_rdata.period);
    take     = (new_rec.remaining != '0) && (!found || (cand_key < best_key));

    dec_rec           = best_rec;
    dec_rec.remaining = best_rec.remaining - 16'd1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptts_pkg::ST_IDLE: begin
        if (cmd_go && (cmd.func == ptts_pkg::FUNC_TICK)) begin
          state_next = (active_n == '0) ? ptts_pkg::ST_FINISH : ptts_pkg::ST_SCAN;
        end
      end
      ptts_pkg::ST_SCAN: begin
        if (last_entry) begin
          state_next = ptts_pkg::ST_FINISH;
        end
      end
      ptts_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_next = ptts_pkg::ST_IDLE;
        end
      end
      default: state_next = ptts_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    cmd.ready = 1'b0;
    rd_addr   = '0;
    tab_we    = 1'b0;
    tab_waddr = IDX_W'(cmd.task_index);
    tab_wdata.exec_time    = cmd.exec_time;
    tab_wdata.period       = cmd.period;
    tab_wdata.rel_deadline = cmd.rel_deadline;
    run_we    = 1'b0;
    run_waddr = proc_idx;
    run_wdata = new_rec;
    unique case (state)
      ptts_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        tab_we    = cmd.valid && (cmd.func == ptts_pkg::FUNC_LOAD) && load_ok;
      end
      ptts_pkg::ST_SCAN: begin
        rd_addr = last_entry ? '0 : proc_idx + IDX_W'(1);
        run_we  = 1'b1;
      end
      ptts_pkg::ST_FINISH: begin
        run_we    = found;
        run_waddr = best_idx;
        run_wdata = dec_rec;
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  assign slot.valid         = slot_valid;
  assign slot.tick_time     = slot_time;
  assign slot.selected_task = slot_task;
  assign slot.idle          = slot_idle;

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ptts_pkg::ST_IDLE;
      policy_mode  <= 1'b0;
      task_count   <= '0;
      tick_counter <= '0;
      work_valid   <= '0;
      dl_valid     <= '0;
      found        <= 1'b0;
      slot_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          ptts_pkg::REG_POLICY_MODE: policy_mode <= cfg_data[0];
          ptts_pkg::REG_TASK_COUNT:  task_count  <= cfg_data[ptts_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end

      if ((state == ptts_pkg::ST_FINISH) && slot_free) begin
        slot_valid <= 1'b1;
      end else if (slot.ready) begin
        slot_valid <= 1'b0;
      end

      unique case (state)
        ptts_pkg::ST_IDLE: begin
          if (cmd_go) begin
            unique case (cmd.func)
              ptts_pkg::FUNC_LOAD: begin
                if (load_ok) begin
                  work_valid[IDX_W'(cmd.task_index)] <= 1'b0;
                end
              end
              ptts_pkg::FUNC_RESTART: begin
                work_valid   <= '0;
                tick_counter <= '0;
              end
              ptts_pkg::FUNC_TICK: begin
                proc_idx <= '0;
                found    <= 1'b0;
                best_idx <= '0;
              end
              default: ;
            endcase
          end
        end
        ptts_pkg::ST_SCAN: begin
          work_valid[proc_idx] <= 1'b1;
          dl_valid[proc_idx]   <= 1'b1;
          if (take) begin
            found    <= 1'b1;
            best_idx <= proc_idx;
            best_key <= cand_key;
            best_rec <= new_rec;
          end
          if (!last_entry) begin
            proc_idx <= proc_idx + IDX_W'(1);
          end
        end
        ptts_pkg::ST_FINISH: begin
          if (slot_free) begin
            slot_time    <= tick_counter;
            slot_task    <= found ? ptts_pkg::TIDX_W'(best_idx) : '0;
            slot_idle    <= !found;
            tick_counter <= tick_counter + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[sim/tb_periodic_task_tick_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler
// Self-checking bench for the periodic task tick scheduler. Command words
// (load, tick, restart, unused code) go in through a bursty valid/ready
// driver. A command-level scheduler model predicts one slot word per tick. The
// monitor checks each slot word field by field against the oldest
// prediction. Phases change policy and task count while the block is idle.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;
  import ptts_pkg::*;

  localparam int          NUM_TASKS   = NUM_TASKS_DEF;
  localparam int          TICK_CYCLES = NUM_TASKS + 2;
  localparam int          SETTLE      = 2 * TICK_CYCLES + 4;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int          ITEM_TARGET = 700;
  localparam int          MAX_PRINTS  = 40;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic              POLICY_RM   = 1'b0;
  localparam logic              POLICY_EDF  = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [TIDX_W-1:0]   task_index;
    logic [TIME16_W-1:0] exec_time;
    logic [TIME16_W-1:0] period;
    logic [TIME16_W-1:0] rel_deadline;
  } cmd_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] tick_time;
    logic [TIDX_W-1:0] selected_task;
    logic              idle;
  } slot_word_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ptts_cmd_if  cmd_ch();
  ptts_slot_if slot_ch();

  periodic_task_tick_scheduler #(
    .NUM_TASKS(NUM_TASKS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd_ch),
    .slot     (slot_ch)
  );

  // scheduler model state
  logic                policy;
  logic [COUNT_W-1:0]  task_cnt;
  logic [TIME_W-1:0]   tick_now;
  logic [TIME16_W-1:0] work_left  [NUM_TASKS];
  logic [TIME_W-1:0]   release_at [NUM_TASKS];
  logic [TIME_W-1:0]   due_at     [NUM_TASKS];
  logic [TIME16_W-1:0] exec_tbl   [NUM_TASKS];
  logic [TIME16_W-1:0] period_tbl [NUM_TASKS];
  logic [TIME16_W-1:0] dl_tbl     [NUM_TASKS];

  cmd_word_t   cmd_backlog[$];
  slot_word_t  expected_slots[$];
  cmd_word_t   next_word;
  logic        cmd_taken;
  logic [15:0] stall_pat;
  int          burst_left;
  int          gap_left;
  int          max_burst;
  int          max_gap;
  int          items_queued;
  int          errors;
  int unsigned cycle_cnt;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void run_scheduler(input cmd_word_t w);
    int         n;
    int         i;
    int         best;
    bit         found;
    slot_word_t s;
    n = (task_cnt > NUM_TASKS) ? NUM_TASKS : int'(task_cnt);
    case (w.func)
      FUNC_LOAD: begin
        exec_tbl[w.task_index]   = w.exec_time;
        period_tbl[w.task_index] = w.period;
        dl_tbl[w.task_index]     = w.rel_deadline;
        work_left[w.task_index]  = '0;
        release_at[w.task_index] = '0;
      end
      FUNC_RESTART: begin
        tick_now = '0;
        for (i = 0; i < NUM_TASKS; i++) begin
          work_left[i]  = '0;
          release_at[i] = '0;
        end
      end
      FUNC_TICK: begin
        for (i = 0; i < n; i++) begin
          if (release_at[i] == tick_now) begin
            work_left[i]  = exec_tbl[i];
            due_at[i]     = tick_now + TIME_W'(dl_tbl[i]);
            release_at[i] = release_at[i] + TIME_W'(period_tbl[i]);
          end
        end
        found = 1'b0;
        best  = 0;
        for (i = 0; i < n; i++) begin
          if (work_left[i] != '0) begin
            if (!found) begin
              best  = i;
              found = 1'b1;
            end else if (policy == POLICY_RM) begin
              if (period_tbl[i] < period_tbl[best]) best = i;
            end else begin
              if (due_at[i] < due_at[best]) best = i;
            end
          end
        end
        if (found) work_left[best] = work_left[best] - 1'b1;
        s.tick_time     = tick_now;
        s.selected_task = found ? TIDX_W'(best) : '0;
        s.idle          = !found;
        expected_slots.push_back(s);
        tick_now = tick_now + 1'b1;
      end
      default: ;
    endcase
  endfunction

  // driver: bursts of words with random gaps
  always @(negedge clk) begin
    if (!rst && (!cmd_ch.valid || cmd_taken)) begin
      if (gap_left > 0 || cmd_backlog.size() == 0) begin
        if (gap_left > 0) gap_left--;
        cmd_ch.valid <= 1'b0;
      end else begin
        next_word = cmd_backlog.pop_front();
        cmd_ch.valid        <= 1'b1;
        cmd_ch.func         <= next_word.func;
        cmd_ch.task_index   <= next_word.task_index;
        cmd_ch.exec_time    <= next_word.exec_time;
        cmd_ch.period       <= next_word.period;
        cmd_ch.rel_deadline <= next_word.rel_deadline;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, max_burst);
          gap_left   = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst) begin
      slot_ch.ready <= 1'b0;
    end else begin
      slot_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // monitor: check slot words, predict on accepted command words
  always @(posedge clk) begin
    cmd_word_t  got_cmd;
    slot_word_t want;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      if (slot_ch.valid && slot_ch.ready) begin
        if (expected_slots.size() == 0) begin
          report_mismatch($sformatf("unexpected slot word tick_time=%0d task=%0d idle=%0b",
                                    slot_ch.tick_time, slot_ch.selected_task, slot_ch.idle));
        end else begin
          want = expected_slots.pop_front();
          if (slot_ch.tick_time !== want.tick_time)
            report_mismatch($sformatf("tick_time got %0d want %0d",
                                      slot_ch.tick_time, want.tick_time));
          if (slot_ch.selected_task !== want.selected_task)
            report_mismatch($sformatf("tick %0d selected_task got %0d want %0d",
                                      want.tick_time, slot_ch.selected_task,
                                      want.selected_task));
          if (slot_ch.idle !== want.idle)
            report_mismatch($sformatf("tick %0d idle got %0b want %0b",
                                      want.tick_time, slot_ch.idle, want.idle));
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        got_cmd.func         = cmd_ch.func;
        got_cmd.task_index   = cmd_ch.task_index;
        got_cmd.exec_time    = cmd_ch.exec_time;
        got_cmd.period       = cmd_ch.period;
        got_cmd.rel_deadline = cmd_ch.rel_deadline;
        run_scheduler(got_cmd);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic cmd_word_t cmd_word(input logic [FUNC_W-1:0] f,
                                         input logic [TIDX_W-1:0] idx,
                                         input logic [TIME16_W-1:0] e,
                                         input logic [TIME16_W-1:0] p,
                                         input logic [TIME16_W-1:0] d);
    cmd_word_t w;
    w.func         = f;
    w.task_index   = idx;
    w.exec_time    = e;
    w.period       = p;
    w.rel_deadline = d;
    return w;
  endfunction

  task automatic queue_cmd(input cmd_word_t w);
    cmd_backlog.push_back(w);
    if (w.func != FUNC_UNUSED) items_queued++;
  endtask

  task automatic queue_ticks(input int n);
    int k;
    for (k = 0; k < n; k++) queue_cmd(cmd_word(FUNC_TICK, '0, '0, '0, '0));
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    case (r)
      REG_POLICY_MODE: policy = v[0];
      REG_TASK_COUNT:  task_cnt = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // block idle: nothing pending, nothing expected, last word's work done
  task automatic wait_drained();
    @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || expected_slots.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_traffic(input bit calm);
    if (calm) begin
      max_gap   = 0;
      max_burst = 64;
      stall_pat = 16'hFFFF;
    end else begin
      max_gap   = $urandom_range(1, 8);
      max_burst = $urandom_range(0, 12);
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
  endtask

  task automatic random_phase();
    int                  k;
    int                  n;
    logic [TIME16_W-1:0] p;
    logic [CFG_DATA_W-1:0] cnt;
    case ($urandom_range(0, 5))
      0:       cnt = 4'd0;
      1:       cnt = 4'd15;
      2:       cnt = 4'(NUM_TASKS);
      default: cnt = 4'($urandom_range(1, NUM_TASKS));
    endcase
    write_reg(REG_POLICY_MODE, 4'($urandom_range(0, 1)));
    write_reg(REG_TASK_COUNT, cnt);
    @(posedge clk);
    set_traffic($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 4) != 0) begin
      n = $urandom_range(1, NUM_TASKS);
      for (k = 0; k < n; k++) begin
        p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
        queue_cmd(cmd_word(FUNC_LOAD, 3'($urandom_range(0, 7)),
                           16'($urandom_range(0, 6)), p,
                           16'($urandom_range(0, 2 * int'(p[7:0]) + 2))));
      end
      queue_cmd(cmd_word(FUNC_RESTART, '0, '0, '0, '0));
      n = $urandom_range(10, 60);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 39))
          0: queue_cmd(cmd_word(FUNC_RESTART, 3'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom)));
          1: queue_cmd(cmd_word(FUNC_UNUSED, 3'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom)));
          2: queue_cmd(cmd_word(FUNC_LOAD, 3'($urandom), 16'($urandom_range(0, 5)),
                                16'($urandom_range(1, 12)), 16'($urandom_range(0, 20))));
          default: queue_ticks(1);
        endcase
      end
    end else begin
      n = $urandom_range(5, 30);
      for (k = 0; k < n; k++)
        queue_cmd(cmd_word(2'($urandom_range(0, 3)), 3'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom)));
    end
    wait_drained();
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = REG_POLICY_MODE;
    cfg_data             = '0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.func          = FUNC_LOAD;
    cmd_ch.task_index    = '0;
    cmd_ch.exec_time     = '0;
    cmd_ch.period        = '0;
    cmd_ch.rel_deadline  = '0;
    slot_ch.ready        = 1'b0;
    cmd_taken            = 1'b0;
    stall_pat            = 16'hFFFF;
    burst_left           = 0;
    gap_left             = 0;
    max_burst            = 64;
    max_gap              = 0;
    items_queued         = 0;
    errors               = 0;
    cycle_cnt            = 0;
    policy               = POLICY_RM;
    task_cnt             = '0;
    tick_now             = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      work_left[i]  = '0;
      release_at[i] = '0;
      due_at[i]     = '0;
      exec_tbl[i]   = '0;
      period_tbl[i] = '0;
      dl_tbl[i]     = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no tasks taking part yet, then fill the whole table
    set_traffic(1'b0);
    queue_ticks(2);
    queue_cmd(cmd_word(FUNC_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_cmd(cmd_word(FUNC_LOAD, 3'd0, 16'd3, 16'd4, 16'd4));
    queue_cmd(cmd_word(FUNC_LOAD, 3'd1, 16'd0, 16'd2, 16'hFFFF));
    queue_cmd(cmd_word(FUNC_LOAD, 3'd2, 16'd1, 16'd0, 16'd1));
    queue_cmd(cmd_word(FUNC_LOAD, 3'd3, 16'hFFFF, 16'hFFFF, 16'd0));
    queue_cmd(cmd_word(FUNC_LOAD, 3'd4, 16'd2, 16'd4, 16'd3));
    queue_cmd(cmd_word(FUNC_LOAD, 3'd5, 16'd1, 16'd3, 16'd2));
    queue_cmd(cmd_word(FUNC_LOAD, 3'd6, 16'd2, 16'd6, 16'd6));
    queue_cmd(cmd_word(FUNC_LOAD, 3'd7, 16'd5, 16'h8000, 16'h7FFF));
    wait_drained();

    // oversized task count, rate monotonic
    write_reg(REG_TASK_COUNT, 4'd15);
    @(posedge clk);
    queue_cmd(cmd_word(FUNC_RESTART, '0, '0, '0, '0));
    queue_ticks(6);
    wait_drained();

    // earliest deadline over the full table
    write_reg(REG_POLICY_MODE, 4'(POLICY_EDF));
    write_reg(REG_TASK_COUNT, 4'(NUM_TASKS));
    @(posedge clk);
    set_traffic(1'b1);
    queue_cmd(cmd_word(FUNC_RESTART, '0, '0, '0, '0));
    queue_ticks(5);
    wait_drained();

    while (items_queued < ITEM_TARGET) random_phase();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
